// ===== hdl/uk_summer_time_local_clock_macros.svh =====
// Assertion macros shared by the checker of the UK summer-time clock.
// Depends on nothing; take it in with a plain include.
`ifndef UK_SUMMER_TIME_LOCAL_CLOCK_MACROS_SVH
`define UK_SUMMER_TIME_LOCAL_CLOCK_MACROS_SVH

// Same-cycle implication, disabled during reset
`define UKST_ASSERT_IMP(name, ck, rs, ante, cons) \
  name: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("ukst same-cycle check failed");

// Next-cycle implication, disabled during reset
`define UKST_ASSERT_NEXT(name, ck, rs, ante, cons) \
  name: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("ukst next-cycle check failed");

`endif

// ===== hdl/ukst_pkg.sv =====
// Constants, types and small helpers for the UK summer-time clock.
// Used by the pipeline control and the top level; depends on nothing.
package ukst_pkg;

  // Pipeline depth, output register included
  localparam int unsigned NUM_STAGES = 15;

  // Beat widths
  localparam int unsigned IN_W  = 32;
  localparam int unsigned OUT_W = 24;

  // Time constants
  localparam int unsigned SECS_PER_DAY  = 86400;
  localparam int unsigned SECS_PER_HOUR = 3600;
  localparam int unsigned SECS_PER_MIN  = 60;
  localparam int unsigned DAYS_PER_YEAR = 365;

  // Reciprocals for constant division (value, shift noted beside each)
  localparam int unsigned RECIP_675   = 6362914; // (t >> 7) / 675, shift 32
  localparam int unsigned RECIP_1460  = 367720;  // shift 29
  localparam int unsigned RECIP_365   = 367720;  // shift 27
  localparam int unsigned RECIP_7     = 74899;   // shift 19
  localparam int unsigned RECIP_3600  = 74566;   // shift 28
  localparam int unsigned RECIP_60    = 4370;    // shift 18

  // Era handling: epoch day 11017 is 2000-03-01
  localparam int unsigned ERA5_FIRST_DAY = 11017;
  localparam int unsigned ERA4_DOE_SHIFT = 135080;
  localparam int unsigned ERA_LAST_DOE   = 146096;
  localparam int unsigned CENTURY_DAYS   = 36524;
  localparam int unsigned JAN_FIRST_DOY  = 306;
  localparam int unsigned ERA4_YEAR      = 1600;
  localparam int unsigned ERA5_YEAR      = 2000;

  // 31 March from the era base: era 5 adds 11017 + 30, era 4 drops 135080 - 30
  localparam int unsigned MAR31_ERA5_ADD = 11047;
  localparam int unsigned MAR31_ERA4_SUB = 135050;
  localparam int unsigned MAR_TO_OCT     = 214;
  localparam int unsigned THURSDAY       = 4;
  localparam int unsigned WEEK_DAYS      = 7;

  typedef struct packed {
    logic [NUM_STAGES-1:0] load;
    logic [NUM_STAGES-1:0] valid;
  } pipe_ctl_t;

  // Whole centuries in a day-of-era value (0..4)
  function automatic logic [2:0] div_century(input logic [17:0] doe);
    logic [2:0] n;
    n = 3'd0;
    if (doe >= 18'(CENTURY_DAYS))     n = 3'd1;
    if (doe >= 18'(2 * CENTURY_DAYS)) n = 3'd2;
    if (doe >= 18'(3 * CENTURY_DAYS)) n = 3'd3;
    if (doe >= 18'(4 * CENTURY_DAYS)) n = 3'd4;
    return n;
  endfunction

  // Year-of-era divided by 100 (0..3)
  function automatic logic [1:0] div_hundred(input logic [8:0] yoe);
    logic [1:0] n;
    n = 2'd0;
    if (yoe >= 9'd100) n = 2'd1;
    if (yoe >= 9'd200) n = 2'd2;
    if (yoe >= 9'd300) n = 2'd3;
    return n;
  endfunction

endpackage

// ===== hdl/uk_summer_time_local_clock.sv =====
// UK civil time from a UTC timestamp: the top level and its datapath stages.
// Depends on ukst_pkg and ukst_pipe_ctl.
//
// Takes one UTC timestamp (seconds since 1970) per beat and returns one beat with
// the British Summer Time flag and the local hour, minute and second. The block
// accepts a new timestamp every cycle unless a stall on the output side has backed
// up to the input; each result passes through the 15-stage pipeline (day split,
// calendar year, last-Sunday search, offset and time-of-day split). A stall on
// the output side holds the pipeline, and empty stages still fill while the output
// waits.
module uk_summer_time_local_clock (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,  // [31:0] utc_seconds
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata   // [0] summer_time, [5:1] local_hour,
                                // [11:6] local_minute, [17:12] local_second, [23:18] zero
);
  import ukst_pkg::*;

  pipe_ctl_t ctl;

  ukst_pipe_ctl u_ctl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .out_ready (m_tready),
    .ctl       (ctl)
  );

  // Stage 0: estimate day number by reciprocal of 675 on t >> 7
  logic [47:0] day_prod;
  logic [31:0] t0;
  logic [15:0] q0;

  assign day_prod = 48'(s_tdata[31:7]) * 48'(RECIP_675);

  always_ff @(posedge clk) begin
    if (ctl.load[0]) begin
      t0 <= s_tdata;
      q0 <= day_prod[47:32];
    end
  end

  // Stage 1: form estimate times seconds per day
  logic [32:0] day_mul;
  logic [31:0] t1;
  logic [15:0] q1;
  logic [31:0] p1;

  assign day_mul = 33'(q0) * 33'(SECS_PER_DAY);

  always_ff @(posedge clk) begin
    if (ctl.load[1]) begin
      t1 <= t0;
      q1 <= q0;
      p1 <= day_mul[31:0];
    end
  end

  // Stage 2: correct the estimate by at most one day
  logic [31:0] rem_full;
  logic [17:0] rem_day;
  logic [15:0] day2;
  logic [16:0] sod2;

  assign rem_full = t1 - p1;
  assign rem_day  = rem_full[17:0];

  always_ff @(posedge clk) begin
    if (ctl.load[2]) begin
      if (rem_day >= 18'(SECS_PER_DAY)) begin
        day2 <= q1 + 16'd1;
        sod2 <= 17'(rem_day - 18'(SECS_PER_DAY));
      end else begin
        day2 <= q1;
        sod2 <= rem_day[16:0];
      end
    end
  end

  // Stage 3: split into 400-year era and day of era
  logic        era5_now;
  logic [17:0] doe3;
  logic        era3;
  logic [15:0] day3;
  logic [16:0] sod3;

  assign era5_now = day2 >= 16'(ERA5_FIRST_DAY);

  always_ff @(posedge clk) begin
    if (ctl.load[3]) begin
      doe3 <= era5_now ? 18'(day2) - 18'(ERA5_FIRST_DAY)
                       : 18'(day2) + 18'(ERA4_DOE_SHIFT);
      era3 <= era5_now;
      day3 <= day2;
      sod3 <= sod2;
    end
  end

  // Stage 4: leap-cycle corrections of day of era
  logic [36:0] quad_prod;
  logic [6:0]  a4;
  logic [2:0]  b4;
  logic        c4;
  logic [17:0] doe4;
  logic        era4;
  logic [15:0] day4;
  logic [16:0] sod4;

  assign quad_prod = 37'(doe3) * 37'(RECIP_1460);

  always_ff @(posedge clk) begin
    if (ctl.load[4]) begin
      a4   <= quad_prod[35:29];
      b4   <= div_century(doe3);
      c4   <= doe3 == 18'(ERA_LAST_DOE);
      doe4 <= doe3;
      era4 <= era3;
      day4 <= day3;
      sod4 <= sod3;
    end
  end

  // Stage 5: year of era by reciprocal of 365
  logic [17:0] yoe_num;
  logic [35:0] yoe_prod;
  logic [8:0]  yoe5;
  logic [17:0] doe5;
  logic        era5;
  logic [15:0] day5;
  logic [16:0] sod5;

  assign yoe_num  = doe4 - 18'(a4) + 18'(b4) - 18'(c4);
  assign yoe_prod = 36'(yoe_num) * 36'(RECIP_365);

  always_ff @(posedge clk) begin
    if (ctl.load[5]) begin
      yoe5 <= yoe_prod[35:27];
      doe5 <= doe4;
      era5 <= era4;
      day5 <= day4;
      sod5 <= sod4;
    end
  end

  // Stage 6: day of year, then calendar year (January and February roll over)
  logic [17:0] yoe_days;
  logic [17:0] doy;
  logic        jan_feb;
  logic [11:0] year6;
  logic [15:0] day6;
  logic [16:0] sod6;

  assign yoe_days = 18'(yoe5) * 18'(DAYS_PER_YEAR) + 18'(yoe5[8:2])
                  - 18'(div_hundred(yoe5));
  assign doy      = doe5 - yoe_days;
  assign jan_feb  = doy >= 18'(JAN_FIRST_DOY);

  always_ff @(posedge clk) begin
    if (ctl.load[6]) begin
      year6 <= 12'(yoe5) + (era5 ? 12'(ERA5_YEAR) : 12'(ERA4_YEAR)) + 12'(jan_feb);
      day6  <= day5;
      sod6  <= sod5;
    end
  end

  // Stage 7: epoch day of 31 March of that year
  logic        yr_era5;
  logic [11:0] yr_off;
  logic [8:0]  yr_yoe;
  logic [17:0] yr_base;
  logic [15:0] mar7;
  logic [15:0] day7;
  logic [16:0] sod7;

  assign yr_era5 = year6 >= 12'(ERA5_YEAR);
  assign yr_off  = year6 - (yr_era5 ? 12'(ERA5_YEAR) : 12'(ERA4_YEAR));
  assign yr_yoe  = yr_off[8:0];
  assign yr_base = 18'(yr_yoe) * 18'(DAYS_PER_YEAR) + 18'(yr_yoe[8:2])
                 - 18'(div_hundred(yr_yoe));

  always_ff @(posedge clk) begin
    if (ctl.load[7]) begin
      mar7 <= yr_era5 ? 16'(yr_base + 18'(MAR31_ERA5_ADD))
                      : 16'(yr_base - 18'(MAR31_ERA4_SUB));
      day7 <= day6;
      sod7 <= sod6;
    end
  end

  // Stage 8: weekday quotient by reciprocal of 7
  logic [16:0] wk_num7;
  logic [33:0] wk_prod;
  logic [12:0] wq8;
  logic [15:0] mar8;
  logic [15:0] day8;
  logic [16:0] sod8;

  assign wk_num7 = 17'(mar7) + 17'(THURSDAY);
  assign wk_prod = 34'(wk_num7) * 34'(RECIP_7);

  always_ff @(posedge clk) begin
    if (ctl.load[8]) begin
      wq8  <= wk_prod[31:19];
      mar8 <= mar7;
      day8 <= day7;
      sod8 <= sod7;
    end
  end

  // Stage 9: step back to the last Sunday of March and of October
  logic [16:0] wk_num8;
  logic [16:0] wk_rem;
  logic [2:0]  wd_mar;
  logic [2:0]  wd_oct;
  logic [15:0] sd9;
  logic [15:0] ed9;
  logic [15:0] day9;
  logic [16:0] sod9;

  assign wk_num8 = 17'(mar8) + 17'(THURSDAY);
  assign wk_rem  = wk_num8 - 17'(wq8) * 17'(WEEK_DAYS);
  assign wd_mar  = wk_rem[2:0];
  // October 31 falls 214 days on, four weekdays later
  assign wd_oct  = (wd_mar >= 3'(WEEK_DAYS - THURSDAY)) ? wd_mar - 3'(WEEK_DAYS - THURSDAY)
                                                        : wd_mar + 3'(THURSDAY);

  always_ff @(posedge clk) begin
    if (ctl.load[9]) begin
      sd9  <= mar8 - 16'(wd_mar);
      ed9  <= mar8 + 16'(MAR_TO_OCT) - 16'(wd_oct);
      day9 <= day8;
      sod9 <= sod8;
    end
  end

  // Stage 10: compare against both 01:00 UTC instants, apply the offset
  logic        after_start;
  logic        before_end;
  logic        bst_now;
  logic [17:0] tod_sum;
  logic        bst10;
  logic [16:0] tod10;

  assign after_start = (day9 > sd9) || ((day9 == sd9) && (sod9 >= 17'(SECS_PER_HOUR)));
  assign before_end  = (day9 < ed9) || ((day9 == ed9) && (sod9 < 17'(SECS_PER_HOUR)));
  assign bst_now     = after_start && before_end;
  assign tod_sum     = 18'(sod9) + (bst_now ? 18'(SECS_PER_HOUR) : 18'd0);

  always_ff @(posedge clk) begin
    if (ctl.load[10]) begin
      bst10 <= bst_now;
      // Wrap past midnight
      tod10 <= (tod_sum >= 18'(SECS_PER_DAY)) ? 17'(tod_sum - 18'(SECS_PER_DAY))
                                              : tod_sum[16:0];
    end
  end

  // Stage 11: hour by reciprocal of 3600
  logic [33:0] hr_prod;
  logic [4:0]  hr11;
  logic [16:0] tod11;
  logic        bst11;

  assign hr_prod = 34'(tod10) * 34'(RECIP_3600);

  always_ff @(posedge clk) begin
    if (ctl.load[11]) begin
      hr11  <= hr_prod[32:28];
      tod11 <= tod10;
      bst11 <= bst10;
    end
  end

  // Stage 12: seconds within the hour
  logic [16:0] hr_secs;
  logic [16:0] hr_rem;
  logic [11:0] rem12;
  logic [4:0]  hr12;
  logic        bst12;

  assign hr_secs = 17'(hr11) * 17'(SECS_PER_HOUR);
  assign hr_rem  = tod11 - hr_secs;

  always_ff @(posedge clk) begin
    if (ctl.load[12]) begin
      rem12 <= hr_rem[11:0];
      hr12  <= hr11;
      bst12 <= bst11;
    end
  end

  // Stage 13: minute by reciprocal of 60
  logic [24:0] mn_prod;
  logic [5:0]  mn13;
  logic [11:0] rem13;
  logic [4:0]  hr13;
  logic        bst13;

  assign mn_prod = 25'(rem12) * 25'(RECIP_60);

  always_ff @(posedge clk) begin
    if (ctl.load[13]) begin
      mn13  <= mn_prod[23:18];
      rem13 <= rem12;
      hr13  <= hr12;
      bst13 <= bst12;
    end
  end

  // Stage 14: second and output register
  logic [11:0] sec_full;
  logic        summer_time;
  logic [4:0]  local_hour;
  logic [5:0]  local_minute;
  logic [5:0]  local_second;

  assign sec_full = rem13 - 12'(mn13) * 12'(SECS_PER_MIN);

  always_ff @(posedge clk) begin
    if (ctl.load[14]) begin
      summer_time  <= bst13;
      local_hour   <= hr13;
      local_minute <= mn13;
      local_second <= sec_full[5:0];
    end
  end

  assign m_tvalid = ctl.valid[NUM_STAGES-1];
  assign m_tdata  = {6'd0, local_second, local_minute, local_hour, summer_time};

endmodule

// ===== hdl/ukst_pipe_ctl.sv =====
// Valid and load control for the clock pipeline, with bubble collapsing.
// Depends on ukst_pkg.
module ukst_pipe_ctl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              out_ready,
  output ukst_pkg::pipe_ctl_t ctl
);
  import ukst_pkg::*;

  logic [NUM_STAGES-1:0] valid;
  logic [NUM_STAGES-1:0] valid_next;
  logic [NUM_STAGES:0]   rdy;

  // A stage may load when it is empty or the stage after it moves
  always_comb begin
    rdy[NUM_STAGES] = out_ready;
    for (int i = NUM_STAGES - 1; i >= 0; i--) begin
      rdy[i] = !valid[i] || rdy[i+1];
    end
  end

  assign valid_next = {valid[NUM_STAGES-2:0], in_valid};

  // Advance valid bits stage by stage
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      for (int i = 0; i < NUM_STAGES; i++) begin
        if (rdy[i]) begin
          valid[i] <= valid_next[i];
        end
      end
    end
  end

  assign in_ready  = rdy[0];
  assign ctl.load  = rdy[NUM_STAGES-1:0];
  assign ctl.valid = valid;

endmodule

// ===== hdl/ukst_checker.sv =====
// Port-level checks on the UK summer-time clock, bound to its top level.
// Depends on the assertion macros header.
`include "uk_summer_time_local_clock_macros.svh"

module ukst_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [31:0] s_tdata,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [23:0] m_tdata
);

  // Hour, minute and second of the beat on offer lie within a day
  logic tod_ok;

  assign tod_ok = (m_tdata[5:1] <= 5'd23) && (m_tdata[11:6] <= 6'd59)
               && (m_tdata[17:12] <= 6'd59);

  // A waiting input beat holds until taken
  `UKST_ASSERT_NEXT(a_in_hold, clk, rst, s_tvalid && !s_tready, s_tvalid && $stable(s_tdata))

  // A stalled result beat holds
  `UKST_ASSERT_NEXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

  // Output side taking data, or no result on offer, frees the whole pipeline for a new beat
  `UKST_ASSERT_IMP(a_ready_flow, clk, rst, m_tready || !m_tvalid, s_tready)

  // Time-of-day fields stay in range
  `UKST_ASSERT_IMP(a_tod_range, clk, rst, m_tvalid, tod_ok)

  // Padding bits are zero
  `UKST_ASSERT_IMP(a_pad_zero, clk, rst, m_tvalid, m_tdata[23:18] == 6'd0)

endmodule

bind uk_summer_time_local_clock ukst_checker u_ukst_checker (.*);
